/* rtl/set_associative_lru_cache_sim_defines.svh */
// Assertion macros used by the top-level file to check this block.
`ifndef SET_ASSOCIATIVE_LRU_CACHE_SIM_DEFINES_SVH
`define SET_ASSOCIATIVE_LRU_CACHE_SIM_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define SALC_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define SALC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/salc_pkg.sv */
package salc_pkg;

    localparam int FULL_WIDTH     = 64;
    localparam int OP_W           = 2;
    localparam int SETB_W         = 3;
    localparam int BLKB_W         = 6;
    localparam int WAYS_W         = 4;
    localparam int CNT_W          = 32;
    localparam int HITS_W         = 2;
    localparam int SH_W           = 7;
    localparam int CFG_IDX_W      = 2;
    localparam int CFG_DATA_W     = 6;

    localparam int MAX_SET_BITS_DEF = 6;
    localparam int MAX_WAYS_DEF     = 8;
    localparam int ADDR_WIDTH_DEF   = 64;

    localparam logic [WAYS_W-1:0] WAYS_RST = WAYS_W'(1);

    localparam logic [OP_W-1:0] OP_LOAD   = 2'd0;
    localparam logic [OP_W-1:0] OP_STORE  = 2'd1;
    localparam logic [OP_W-1:0] OP_MODIFY = 2'd2;
    localparam logic [OP_W-1:0] OP_NONE   = 2'd3;

    localparam logic [CFG_IDX_W-1:0] REG_SET_BITS   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BLOCK_BITS = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_WAYS_USED  = 2'd2;

    typedef struct packed {
        logic load_in;
        logic rd;
        logic ev;
        logic clr;
        logic load_out;
    } t_cmd;

    typedef struct packed {
        logic clr_last;
        logic op_none;
        logic op_modify;
    } t_sts;

endpackage

/* rtl/salc_in_if.sv */
interface salc_in_if #(
    parameter int ADDR_WIDTH = salc_pkg::ADDR_WIDTH_DEF
);
    import salc_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [OP_W-1:0]       op;
    logic [ADDR_WIDTH-1:0] address;

    modport source (output valid, output op, output address, input ready);
    modport sink   (input valid, input op, input address, output ready);
endinterface

/* rtl/salc_out_if.sv */
interface salc_out_if;
    import salc_pkg::*;

    logic              valid;
    logic              ready;
    logic [HITS_W-1:0] hits_now;
    logic              missed;
    logic              evicted;
    logic [CNT_W-1:0]  total_hits;
    logic [CNT_W-1:0]  total_misses;
    logic [CNT_W-1:0]  total_evictions;

    modport source (output valid, output hits_now, output missed, output evicted,
                    output total_hits, output total_misses, output total_evictions,
                    input ready);
    modport sink   (input valid, input hits_now, input missed, input evicted,
                    input total_hits, input total_misses, input total_evictions,
                    output ready);
endinterface

/* rtl/salc_ctrl.sv */
module salc_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    output salc_pkg::t_cmd o_cmd,
    input  salc_pkg::t_sts i_sts
);
    import salc_pkg::*;

    typedef enum logic [4:0] {
        S_CLR  = 5'b00001,
        S_IDLE = 5'b00010,
        S_RD   = 5'b00100,
        S_EV   = 5'b01000,
        S_FIN  = 5'b10000
    } t_state;

    t_state r_state, n_state;
    logic   r_second, n_second;
    logic   r_out_valid, n_out_valid;

    always_comb begin
        n_state     = r_state;
        n_second    = r_second;
        n_out_valid = r_out_valid;
        o_cmd       = '0;
        o_in_ready  = 1'b0;
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end
        case (r_state)
            S_CLR: begin
                o_cmd.clr = 1'b1;
                if (i_sts.clr_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load_in = 1'b1;
                    n_second      = 1'b0;
                    n_state       = S_RD;
                end
            end
            S_RD: begin
                o_cmd.rd = 1'b1;
                n_state  = i_sts.op_none ? S_FIN : S_EV;
            end
            S_EV: begin
                o_cmd.ev = 1'b1;
                if (i_sts.op_modify && !r_second) begin
                    // A modify runs the same set access a second time.
                    n_second = 1'b1;
                    n_state  = S_RD;
                end else begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.load_out = 1'b1;
                    n_out_valid    = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_CLR;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLR;
            r_second    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_second    <= n_second;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

/* rtl/salc_dp.sv */
module salc_dp #(
    parameter int MAX_SET_BITS = salc_pkg::MAX_SET_BITS_DEF,
    parameter int MAX_WAYS     = salc_pkg::MAX_WAYS_DEF,
    parameter int ADDR_WIDTH   = salc_pkg::ADDR_WIDTH_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  salc_pkg::t_cmd                   i_cmd,
    output salc_pkg::t_sts                   o_sts,
    input  logic                             i_cfg_we,
    input  logic [salc_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [salc_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    input  logic [salc_pkg::OP_W-1:0]        i_op,
    input  logic [ADDR_WIDTH-1:0]            i_address,
    output logic [salc_pkg::HITS_W-1:0]      o_hits_now,
    output logic                             o_missed,
    output logic                             o_evicted,
    output logic [salc_pkg::CNT_W-1:0]       o_total_hits,
    output logic [salc_pkg::CNT_W-1:0]       o_total_misses,
    output logic [salc_pkg::CNT_W-1:0]       o_total_evictions
);
    import salc_pkg::*;

    localparam int IDX_W    = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1;
    localparam int NUM_ROWS = 1 << IDX_W;
    localparam int RANK_W   = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
    localparam int WI_W     = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
    localparam int NW_W     = WAYS_W + 1;
    localparam logic [RANK_W-1:0] RANK_TOP = RANK_W'(MAX_WAYS - 1);

    typedef struct packed {
        logic                  valid;
        logic [RANK_W-1:0]     rank;
        logic [ADDR_WIDTH-1:0] tag;
    } t_line;

    typedef t_line [MAX_WAYS-1:0] t_row;

    // Configuration registers.
    logic [SETB_W-1:0] r_set_bits;
    logic [BLKB_W-1:0] r_block_bits;
    logic [WAYS_W-1:0] r_ways_used;

    // Current item.
    logic [OP_W-1:0]       r_op;
    logic [ADDR_WIDTH-1:0] r_addr;
    logic [ADDR_WIDTH-1:0] r_tag;
    logic [IDX_W-1:0]      r_idx;
    logic [IDX_W-1:0]      r_clr_cnt;

    logic [HITS_W-1:0] r_hits;
    logic              r_missed;
    logic              r_evicted;
    logic [CNT_W-1:0]  r_hit_total;
    logic [CNT_W-1:0]  r_miss_total;
    logic [CNT_W-1:0]  r_evict_total;

    logic [HITS_W-1:0] r_out_hits;
    logic              r_out_missed;
    logic              r_out_evicted;
    logic [CNT_W-1:0]  r_out_hit_total;
    logic [CNT_W-1:0]  r_out_miss_total;
    logic [CNT_W-1:0]  r_out_evict_total;

    t_row r_mem [NUM_ROWS];
    t_row r_rd_row;
    t_row n_row;

    logic [SH_W-1:0]       sb;
    logic [SH_W-1:0]       sh;
    logic [ADDR_WIDTH-1:0] tag_calc;
    logic [ADDR_WIDTH-1:0] idx_shift;
    logic [IDX_W-1:0]      idx_calc;
    logic [NW_W-1:0]       eff_ways;
    logic [MAX_WAYS-1:0]   used;

    logic              hit_any;
    logic              inv_any;
    logic [WI_W-1:0]   hit_way;
    logic [WI_W-1:0]   inv_way;
    logic [WI_W-1:0]   vic_way;
    logic [RANK_W-1:0] vic_rank;
    logic [WI_W-1:0]   t_way;
    logic [RANK_W-1:0] old_rank;
    logic              is_fill;

    logic              mem_we;
    logic [IDX_W-1:0]  mem_wa;
    t_row              mem_wd;

    // Address split.
    always_comb begin
        sb = (SH_W'(r_set_bits) > SH_W'(MAX_SET_BITS)) ? SH_W'(MAX_SET_BITS)
                                                      : SH_W'(r_set_bits);
        sh        = sb + SH_W'(r_block_bits);
        tag_calc  = r_addr >> sh;
        idx_shift = r_addr >> r_block_bits;
        idx_calc  = idx_shift[IDX_W-1:0] & ~({IDX_W{1'b1}} << sb);
    end

    always_comb begin
        if (r_ways_used == '0) begin
            eff_ways = NW_W'(1);
        end else if (NW_W'(r_ways_used) > NW_W'(MAX_WAYS)) begin
            eff_ways = NW_W'(MAX_WAYS);
        end else begin
            eff_ways = NW_W'(r_ways_used);
        end
        for (int w = 0; w < MAX_WAYS; w++) begin
            used[w] = NW_W'(w) < eff_ways;
        end
    end

    // Lookup, replacement choice and LRU update on the registered set row.
    always_comb begin
        hit_any  = 1'b0;
        inv_any  = 1'b0;
        hit_way  = '0;
        inv_way  = '0;
        for (int w = MAX_WAYS - 1; w >= 0; w--) begin
            if (used[w] && r_rd_row[w].valid && r_rd_row[w].tag == r_tag) begin
                hit_any = 1'b1;
                hit_way = WI_W'(w);
            end
            if (used[w] && !r_rd_row[w].valid) begin
                inv_any = 1'b1;
                inv_way = WI_W'(w);
            end
        end

        // Oldest used way; strict compare keeps the lowest way on a tie.
        vic_way  = '0;
        vic_rank = r_rd_row[0].rank;
        for (int w = 1; w < MAX_WAYS; w++) begin
            if (used[w] && r_rd_row[w].rank > vic_rank) begin
                vic_way  = WI_W'(w);
                vic_rank = r_rd_row[w].rank;
            end
        end

        is_fill  = !hit_any && inv_any;
        t_way    = hit_any ? hit_way : (inv_any ? inv_way : vic_way);
        old_rank = hit_any ? r_rd_row[hit_way].rank : vic_rank;

        n_row = r_rd_row;
        for (int w = 0; w < MAX_WAYS; w++) begin
            if (WI_W'(w) != t_way && used[w] && r_rd_row[w].valid &&
                (is_fill || r_rd_row[w].rank < old_rank) &&
                r_rd_row[w].rank != RANK_TOP) begin
                n_row[w].rank = r_rd_row[w].rank + RANK_W'(1);
            end
        end
        n_row[t_way].rank = '0;
        if (!hit_any) begin
            n_row[t_way].valid = 1'b1;
            n_row[t_way].tag   = r_tag;
        end
    end

    assign mem_we = i_cmd.ev | i_cmd.clr;
    assign mem_wa = i_cmd.clr ? r_clr_cnt : r_idx;
    assign mem_wd = i_cmd.clr ? t_row'('0) : n_row;

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_wa] <= mem_wd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.rd) begin
            r_rd_row <= r_mem[idx_calc];
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_op   <= i_op;
            r_addr <= i_address;
        end
        if (i_cmd.rd) begin
            r_tag <= tag_calc;
            r_idx <= idx_calc;
        end
        if (i_cmd.load_out) begin
            r_out_hits        <= r_hits;
            r_out_missed      <= r_missed;
            r_out_evicted     <= r_evicted;
            r_out_hit_total   <= r_hit_total;
            r_out_miss_total  <= r_miss_total;
            r_out_evict_total <= r_evict_total;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_set_bits    <= '0;
            r_block_bits  <= '0;
            r_ways_used   <= WAYS_RST;
            r_clr_cnt     <= '0;
            r_hits        <= '0;
            r_missed      <= 1'b0;
            r_evicted     <= 1'b0;
            r_hit_total   <= '0;
            r_miss_total  <= '0;
            r_evict_total <= '0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_SET_BITS:   r_set_bits   <= i_cfg_data[SETB_W-1:0];
                    REG_BLOCK_BITS: r_block_bits <= i_cfg_data[BLKB_W-1:0];
                    REG_WAYS_USED:  r_ways_used  <= i_cfg_data[WAYS_W-1:0];
                    default: begin
                    end
                endcase
            end
            if (i_cmd.clr) begin
                r_clr_cnt <= r_clr_cnt + IDX_W'(1);
            end
            if (i_cmd.load_in) begin
                r_hits    <= '0;
                r_missed  <= 1'b0;
                r_evicted <= 1'b0;
            end
            if (i_cmd.ev) begin
                if (hit_any) begin
                    r_hits <= r_hits + HITS_W'(1);
                    if (r_hit_total != '1) begin
                        r_hit_total <= r_hit_total + CNT_W'(1);
                    end
                end else begin
                    r_missed <= 1'b1;
                    if (r_miss_total != '1) begin
                        r_miss_total <= r_miss_total + CNT_W'(1);
                    end
                    if (!inv_any) begin
                        r_evicted <= 1'b1;
                        if (r_evict_total != '1) begin
                            r_evict_total <= r_evict_total + CNT_W'(1);
                        end
                    end
                end
            end
        end
    end

    assign o_sts.clr_last  = &r_clr_cnt;
    assign o_sts.op_none   = (r_op == OP_NONE);
    assign o_sts.op_modify = (r_op == OP_MODIFY);

    assign o_hits_now        = r_out_hits;
    assign o_missed          = r_out_missed;
    assign o_evicted         = r_out_evicted;
    assign o_total_hits      = r_out_hit_total;
    assign o_total_misses    = r_out_miss_total;
    assign o_total_evictions = r_out_evict_total;

endmodule

/* rtl/set_associative_lru_cache_sim.sv */
// Each load or store is one read and one write-back of a set row in the line memory; a
// modify does both twice and the unused op code only reads; the next item enters only
// after the result of the last is loaded for output.
// Reset: synchronous, active low; a clearing pass then writes 2**MAX_SET_BITS set rows,
// one per cycle, with no input taken (configuration writes are taken).
`include "set_associative_lru_cache_sim_defines.svh"

module set_associative_lru_cache_sim #(
    parameter int MAX_SET_BITS = salc_pkg::MAX_SET_BITS_DEF,
    parameter int MAX_WAYS     = salc_pkg::MAX_WAYS_DEF,
    parameter int ADDR_WIDTH   = salc_pkg::ADDR_WIDTH_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    salc_in_if.sink                         i_in,
    salc_out_if.source                      o_out,
    input  logic                            i_cfg_we,
    input  logic [salc_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [salc_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import salc_pkg::*;

    t_cmd w_cmd;
    t_sts w_sts;

    salc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (i_in.ready),
        .o_out_valid (o_out.valid),
        .i_out_ready (o_out.ready),
        .o_cmd       (w_cmd),
        .i_sts       (w_sts)
    );

    salc_dp #(
        .MAX_SET_BITS (MAX_SET_BITS),
        .MAX_WAYS     (MAX_WAYS),
        .ADDR_WIDTH   (ADDR_WIDTH)
    ) u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (w_cmd),
        .o_sts             (w_sts),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_idx         (i_cfg_idx),
        .i_cfg_data        (i_cfg_data),
        .i_op              (i_in.op),
        .i_address         (ADDR_WIDTH'(i_in.address)),
        .o_hits_now        (o_out.hits_now),
        .o_missed          (o_out.missed),
        .o_evicted         (o_out.evicted),
        .o_total_hits      (o_out.total_hits),
        .o_total_misses    (o_out.total_misses),
        .o_total_evictions (o_out.total_evictions)
    );

    `SALC_ASSERT_NOW(a_no_input_in_clear, w_cmd.clr, !i_in.ready, "input taken during clear")
    `SALC_ASSERT_NEXT(a_one_item_at_a_time, i_in.valid && i_in.ready, !i_in.ready, "second item taken")
    `SALC_ASSERT_NEXT(a_result_shown, w_cmd.load_out, o_out.valid, "loaded result not shown")
    `SALC_ASSERT_NOW(a_evict_needs_miss, o_out.valid, !(o_out.evicted && !o_out.missed), "evict without miss")

endmodule

/* bench/tb_top.sv */
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import salc_pkg::*;

    localparam int HALF_PERIOD   = 5;
    localparam int RESET_CYCLES  = 5;
    localparam int SET_LOG_MAX   = MAX_SET_BITS_DEF;
    localparam int SET_COUNT     = 1 << MAX_SET_BITS_DEF;
    localparam int LINE_WAYS     = MAX_WAYS_DEF;
    localparam int RANK_TOP      = LINE_WAYS - 1;
    localparam int CYCLE_LIMIT   = 400_000;
    localparam int SETTLE_CYCLES = 8;
    localparam int DRAIN_CYCLES  = 12;
    localparam int HOLD_CYCLES   = 300;
    localparam int REPORT_MAX    = 10;
    localparam int PHASES        = 7;
    localparam int PHASE_ITEMS   = 200;

    typedef struct packed {
        logic [HITS_W-1:0] hits_now;
        logic              missed;
        logic              evicted;
        logic [CNT_W-1:0]  total_hits;
        logic [CNT_W-1:0]  total_misses;
        logic [CNT_W-1:0]  total_evictions;
    } t_cache_result;

    typedef enum logic {ROW_ACCESS, ROW_SETUP} t_row_kind;

    typedef struct {
        t_row_kind          kind;
        logic [OP_W-1:0]    op;
        logic [63:0]        address;
        int                 set_bits;
        int                 block_bits;
        int                 ways;
        logic               known;
        t_cache_result      want;
    } t_stim_row;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_idx = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    salc_in_if #(.ADDR_WIDTH(64)) in_if ();
    salc_out_if                   out_if ();

    set_associative_lru_cache_sim u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (in_if),
        .o_out      (out_if),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    always #(HALF_PERIOD) i_clk = ~i_clk;

    // Cache image kept by the predictor, with the register values it works under.
    bit              line_ok  [SET_COUNT][LINE_WAYS];
    bit [63:0]       line_tag [SET_COUNT][LINE_WAYS];
    bit [2:0]        line_age [SET_COUNT][LINE_WAYS];
    bit [CNT_W-1:0]  hit_cnt;
    bit [CNT_W-1:0]  miss_cnt;
    bit [CNT_W-1:0]  evict_cnt;
    bit [SETB_W-1:0] cur_set_bits = '0;
    bit [BLKB_W-1:0] cur_block_bits = '0;
    bit [WAYS_W-1:0] cur_ways = WAYS_RST;

    t_cache_result pending_results[$];
    logic          known_pending = 1'b0;
    t_cache_result known_result;
    int            fail_count = 0;
    int            checked_count = 0;
    int            sent_count = 0;
    int            settings_count = 0;
    int            cycle_count = 0;
    bit            hold_req = 1'b0;
    bit            no_gap_mode = 1'b0;
    int            burst_left = 0;

    task automatic bump(inout bit [CNT_W-1:0] c);
        if (c != '1) c++;
    endtask

    // Line w of set s becomes most recent; lines younger than its old rank age by one.
    task automatic age_lines(input int s, input int w, input int nways, input int old_rank);
        for (int i = 0; i < nways; i++) begin
            if (i != w && line_ok[s][i] && int'(line_age[s][i]) < old_rank &&
                int'(line_age[s][i]) < RANK_TOP)
                line_age[s][i] = line_age[s][i] + 3'd1;
        end
        line_age[s][w] = '0;
    endtask

    task automatic probe_line(input logic [63:0] address, inout logic [HITS_W-1:0] hits,
                              inout logic miss_f, inout logic evict_f);
        int          sb;
        int          bb;
        int          nways;
        int          s;
        int          pick;
        logic [63:0] tagv;
        logic [63:0] idx;
        sb    = (cur_set_bits > SET_LOG_MAX) ? SET_LOG_MAX : int'(cur_set_bits);
        bb    = int'(cur_block_bits);
        nways = (cur_ways == 0) ? 1 : ((cur_ways > LINE_WAYS) ? LINE_WAYS : int'(cur_ways));
        tagv  = (sb + bb >= 64) ? 64'd0 : (address >> (sb + bb));
        idx   = (address >> bb) & ((64'd1 << sb) - 64'd1);
        s     = int'(idx[5:0]);
        pick  = -1;
        for (int w = 0; w < nways; w++)
            if (pick < 0 && line_ok[s][w] && line_tag[s][w] == tagv) pick = w;
        if (pick >= 0) begin
            age_lines(s, pick, nways, int'(line_age[s][pick]));
            hits++;
            bump(hit_cnt);
        end else begin
            miss_f = 1'b1;
            bump(miss_cnt);
            for (int w = 0; w < nways; w++)
                if (pick < 0 && !line_ok[s][w]) pick = w;
            if (pick >= 0) begin
                age_lines(s, pick, nways, LINE_WAYS);
                line_ok[s][pick]  = 1'b1;
                line_tag[s][pick] = tagv;
            end else begin
                pick = 0;
                for (int w = 1; w < nways; w++)
                    if (line_age[s][w] > line_age[s][pick]) pick = w;
                evict_f = 1'b1;
                bump(evict_cnt);
                age_lines(s, pick, nways, int'(line_age[s][pick]));
                line_tag[s][pick] = tagv;
            end
        end
    endtask

    task automatic predict_access(input logic [OP_W-1:0] op, input logic [63:0] address,
                                  output t_cache_result r);
        logic [HITS_W-1:0] hits;
        logic              miss_f;
        logic              evict_f;
        hits    = '0;
        miss_f  = 1'b0;
        evict_f = 1'b0;
        if (op != OP_NONE) begin
            probe_line(address, hits, miss_f, evict_f);
            if (op == OP_MODIFY) probe_line(address, hits, miss_f, evict_f);
        end
        r = '{hits, miss_f, evict_f, hit_cnt, miss_cnt, evict_cnt};
    endtask

    task automatic report_mismatch(input int n, input t_cache_result want,
                                   input t_cache_result got);
        $display("[%0t] result %0d: expected hits=%0d miss=%0b evict=%0b totals=%0d/%0d/%0d",
                 $realtime, n, want.hits_now, want.missed, want.evicted, want.total_hits,
                 want.total_misses, want.total_evictions);
        $display("[%0t] result %0d: got hits=%0d miss=%0b evict=%0b totals=%0d/%0d/%0d",
                 $realtime, n, got.hits_now, got.missed, got.evicted, got.total_hits,
                 got.total_misses, got.total_evictions);
    endtask

    // Register mirror, the predictor and the result check all run on the sampling edge.
    always @(posedge i_clk) begin
        t_cache_result pred;
        t_cache_result got;
        t_cache_result want;
        if (i_rst_n) begin
            if (cfg_we) begin
                case (cfg_idx)
                    REG_SET_BITS:   cur_set_bits   = cfg_data[SETB_W-1:0];
                    REG_BLOCK_BITS: cur_block_bits = cfg_data[BLKB_W-1:0];
                    REG_WAYS_USED:  cur_ways       = cfg_data[WAYS_W-1:0];
                    default: ;
                endcase
            end
            if (in_if.valid === 1'b1 && in_if.ready === 1'b1) begin
                predict_access(in_if.op, in_if.address, pred);
                if (known_pending) pred = known_result;
                pending_results.push_back(pred);
            end
            if (out_if.valid === 1'b1 && out_if.ready === 1'b1) begin
                got = '{out_if.hits_now, out_if.missed, out_if.evicted, out_if.total_hits,
                        out_if.total_misses, out_if.total_evictions};
                checked_count++;
                if (pending_results.size() == 0) begin
                    fail_count++;
                    if (fail_count <= REPORT_MAX)
                        $display("[%0t] result transfer with nothing pending", $realtime);
                end else begin
                    want = pending_results.pop_front();
                    if (got.hits_now !== want.hits_now || got.missed !== want.missed ||
                        got.evicted !== want.evicted || got.total_hits !== want.total_hits ||
                        got.total_misses !== want.total_misses ||
                        got.total_evictions !== want.total_evictions) begin
                        fail_count++;
                        if (fail_count <= REPORT_MAX)
                            report_mismatch(checked_count, want, got);
                    end
                end
            end
        end
    end

    initial begin : watchdog
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("Mismatches found");
        $finish;
    end

    // The receiver follows a randomly drawn stall pattern, and on request holds off
    // for a long stretch so that the block backs up into its input.
    initial begin : receiver
        logic [15:0] pattern;
        int          step;
        int          hold_left;
        pattern   = 16'hFFFF;
        step      = 0;
        hold_left = 0;
        out_if.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                hold_left = HOLD_CYCLES;
                hold_req  = 1'b0;
            end
            if (step % 64 == 0) begin
                if ($urandom_range(0, 3) == 0) pattern = 16'hFFFF;
                else pattern = 16'($urandom) | 16'h0101;
            end
            if (hold_left > 0) begin
                out_if.ready <= 1'b0;
                hold_left--;
            end else begin
                out_if.ready <= pattern[step % 16];
            end
            step++;
        end
    end

    // Called at a falling edge; returns at a falling edge after the transfer.
    task automatic send_access(input logic [OP_W-1:0] op, input logic [63:0] address);
        in_if.valid   <= 1'b1;
        in_if.op      <= op;
        in_if.address <= address;
        do @(posedge i_clk); while (in_if.ready !== 1'b1);
        @(negedge i_clk);
        sent_count++;
        if (!no_gap_mode) begin
            burst_left--;
            if (burst_left <= 0) begin
                in_if.valid <= 1'b0;
                repeat ($urandom_range(1, 8)) @(negedge i_clk);
                burst_left = $urandom_range(1, 24);
            end
        end
    endtask

    task automatic program_cache(input int sb, input int bb, input int ways);
        in_if.valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= REG_SET_BITS;
        cfg_data <= CFG_DATA_W'(sb);
        @(negedge i_clk);
        cfg_idx  <= REG_BLOCK_BITS;
        cfg_data <= CFG_DATA_W'(bb);
        @(negedge i_clk);
        cfg_idx  <= REG_WAYS_USED;
        cfg_data <= CFG_DATA_W'(ways);
        @(negedge i_clk);
        cfg_we   <= 1'b0;
        @(negedge i_clk);
        settings_count++;
    endtask

    function automatic logic [OP_W-1:0] pick_op();
        int r;
        r = $urandom_range(0, 99);
        if (r < 35) return OP_LOAD;
        if (r < 65) return OP_STORE;
        if (r < 94) return OP_MODIFY;
        return OP_NONE;
    endfunction

    // Mostly addresses built from a small pool of tags and sets so that lines get reused
    // and evicted; the rest is unrelated noise over all 64 bits.
    function automatic logic [63:0] pick_address(input int sb, input int bb, input int nways);
        logic [63:0] tagv;
        logic [63:0] setv;
        logic [63:0] off;
        int          set_top;
        if ($urandom_range(0, 99) < 12) return {$urandom, $urandom};
        tagv = $urandom_range(0, 2 * nways + 1);
        if ($urandom_range(0, 19) == 0) tagv = {$urandom, $urandom};
        set_top = (1 << sb) - 1;
        if ($urandom_range(0, 1) == 0 && set_top > 3) set_top = 3;
        setv = $urandom_range(0, set_top);
        off  = {$urandom, $urandom} & ((64'd1 << bb) - 64'd1);
        return (tagv << (sb + bb)) | (setv << bb) | off;
    endfunction

    function automatic t_stim_row access_row(input logic [OP_W-1:0] op,
                                             input logic [63:0] address);
        return '{ROW_ACCESS, op, address, 0, 0, 0, 1'b0, '0};
    endfunction

    function automatic t_stim_row known_row(input logic [OP_W-1:0] op,
                                            input logic [63:0] address, input int hits,
                                            input int m, input int e, input int th,
                                            input int tm, input int te);
        t_cache_result r;
        r = '{HITS_W'(hits), 1'(m), 1'(e), CNT_W'(th), CNT_W'(tm), CNT_W'(te)};
        return '{ROW_ACCESS, op, address, 0, 0, 0, 1'b1, r};
    endfunction

    function automatic t_stim_row setup_row(input int sb, input int bb, input int ways);
        return '{ROW_SETUP, OP_LOAD, 64'd0, sb, bb, ways, 1'b0, '0};
    endfunction

    initial begin : stimulus
        t_stim_row   rows[$];
        int          ph_sb[PHASES];
        int          ph_bb[PHASES];
        int          ph_ways[PHASES];
        int          sb_eff;
        int          ways_eff;
        logic [63:0] all_ones;
        all_ones = '1;
        ph_sb    = '{0, 6, 7, 2, 3, 0, 0};
        ph_bb    = '{0, 63, 33, 4, 6, 0, 0};
        ph_ways  = '{1, 8, 15, 0, 4, 0, 0};
        ph_sb[5] = $urandom_range(0, 7);
        ph_bb[5] = $urandom_range(0, 63);
        ph_ways[5] = $urandom_range(0, 15);
        ph_sb[6] = $urandom_range(0, 7);
        ph_bb[6] = $urandom_range(0, 12);
        ph_ways[6] = $urandom_range(1, 8);

        in_if.valid   = 1'b0;
        in_if.op      = OP_LOAD;
        in_if.address = '0;
        burst_left    = $urandom_range(1, 24);

        // Reset settings: one set with one line, so every outcome is plain to see.
        rows.push_back(known_row(OP_LOAD,   64'd0,    0, 1, 0, 0, 1, 0));
        rows.push_back(known_row(OP_LOAD,   64'd0,    1, 0, 0, 1, 1, 0));
        rows.push_back(known_row(OP_STORE,  64'd1,    0, 1, 1, 1, 2, 1));
        rows.push_back(known_row(OP_MODIFY, 64'd1,    2, 0, 0, 3, 2, 1));
        rows.push_back(known_row(OP_MODIFY, 64'd2,    1, 1, 1, 4, 3, 2));
        rows.push_back(known_row(OP_NONE,   all_ones, 0, 0, 0, 4, 3, 2));
        rows.push_back(known_row(OP_LOAD,   all_ones, 0, 1, 1, 4, 4, 3));
        rows.push_back(known_row(OP_LOAD,   all_ones, 1, 0, 0, 5, 4, 3));
        // Set bits and way count beyond range, offset so wide that the tag vanishes.
        rows.push_back(setup_row(7, 63, 15));
        rows.push_back(access_row(OP_LOAD,   64'd0));
        rows.push_back(access_row(OP_LOAD,   64'h8000_0000_0000_0000));
        rows.push_back(access_row(OP_STORE,  all_ones));
        rows.push_back(access_row(OP_MODIFY, 64'h7FFF_FFFF_FFFF_FFFF));
        // A way count of zero behaves as one.
        rows.push_back(setup_row(6, 32, 0));
        rows.push_back(access_row(OP_LOAD,  64'h0000_0123_4567_89AB));
        rows.push_back(access_row(OP_STORE, 64'h0000_0023_4567_89AB));
        // Fill all eight ways of one set, push one more in, then revisit.
        rows.push_back(setup_row(3, 4, 8));
        for (int k = 0; k < 9; k++)
            rows.push_back(access_row(OP_LOAD, (64'(k) << 7) | (64'd5 << 4) | 64'(k)));
        rows.push_back(access_row(OP_MODIFY, 64'd5 << 4));

        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (rows[i]) begin
            if (rows[i].kind == ROW_SETUP) begin
                program_cache(rows[i].set_bits, rows[i].block_bits, rows[i].ways);
            end else begin
                known_pending = rows[i].known;
                known_result  = rows[i].want;
                send_access(rows[i].op, rows[i].address);
            end
        end
        known_pending = 1'b0;

        for (int ph = 0; ph < PHASES; ph++) begin
            program_cache(ph_sb[ph], ph_bb[ph], ph_ways[ph]);
            sb_eff   = (ph_sb[ph] > SET_LOG_MAX) ? SET_LOG_MAX : ph_sb[ph];
            ways_eff = (ph_ways[ph] == 0) ? 1 :
                       ((ph_ways[ph] > LINE_WAYS) ? LINE_WAYS : ph_ways[ph]);
            no_gap_mode = (ph == 1);
            if (ph == 3) hold_req = 1'b1;
            for (int n = 0; n < PHASE_ITEMS; n++)
                send_access(pick_op(), pick_address(sb_eff, ph_bb[ph], ways_eff));
        end

        in_if.valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Sent %0d accesses under %0d cache settings; %0d results compared.",
                 sent_count, settings_count, checked_count);
        $display("Predicted totals: %0d hits, %0d misses, %0d evictions.",
                 hit_cnt, miss_cnt, evict_cnt);
        if (fail_count == 0 && pending_results.size() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

/* set_associative_lru_cache_sim.f */
+incdir+rtl
rtl/salc_pkg.sv
rtl/salc_in_if.sv
rtl/salc_out_if.sv
rtl/salc_ctrl.sv
rtl/salc_dp.sv
rtl/set_associative_lru_cache_sim.sv
bench/tb_top.sv
